// ----- hdl/agacc_pkg.sv -----
// Shared types and constants for the annotated group accumulator.
`timescale 1ns / 1ps
package agacc_pkg;

  localparam int unsigned DEFAULT_ROWS          = 1024;
  localparam int unsigned DEFAULT_INTERVENTIONS = 16;
  localparam int unsigned DEFAULT_GROUPS        = 64;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_AGGREGATE_MODE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNGROUPED_MODE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUPS_IN_USE        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVENTIONS_IN_USE = 2'd3;

  localparam logic [6:0] RESET_GROUPS_IN_USE        = 7'd64;
  localparam logic [4:0] RESET_INTERVENTIONS_IN_USE = 5'd16;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_PAIR = 2'd1,
    KIND_READ = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_ADD  = 2'd1,
    OP_READ = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    BK_CLEAR = 2'd0,
    BK_IDLE  = 2'd1,
    BK_EXEC  = 2'd2
  } bk_state_e;

  typedef struct packed {
    logic [1:0]                kind;
    logic [9:0]                row_index;
    logic [3:0]                row_annotation;
    logic signed [VALUE_W-1:0] row_value;
    logic [5:0]                group_index;
    logic [3:0]                intervention_index;
  } in_item_t;

  typedef struct packed {
    logic                      status;
    logic signed [VALUE_W-1:0] entry_value;
  } out_item_t;

  typedef struct packed {
    logic       aggregate_mode;
    logic       ungrouped_mode;
    logic [6:0] groups_in_use;
    logic [4:0] interventions_in_use;
  } cfg_t;

  // Work handed from the front to the back
  typedef struct packed {
    op_e                op;
    logic               status;
    logic [3:0]         ann;
    logic [5:0]         grp;
    logic [VALUE_W-1:0] inc;
  } cmd_t;

  typedef struct packed {
    logic [3:0]         ann;
    logic [VALUE_W-1:0] value;
  } row_entry_t;

endpackage

// ----- hdl/agacc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module agacc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/agacc_fifo.sv -----
// Small register queue used between the front and the back and on the result side.
`timescale 1ns / 1ps
module agacc_fifo #(
  parameter type         T     = logic,
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     wdata_i,
  output logic full_o,
  input  logic pop_i,
  output T     rdata_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  T              mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ----- hdl/agacc_front.sv -----
// Front end: takes items, checks ranges, keeps the row store, issues commands.
`timescale 1ns / 1ps
module agacc_front #(
  parameter int unsigned ROWS          = agacc_pkg::DEFAULT_ROWS,
  parameter int unsigned INTERVENTIONS = agacc_pkg::DEFAULT_INTERVENTIONS,
  parameter int unsigned GROUPS        = agacc_pkg::DEFAULT_GROUPS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  agacc_pkg::cfg_t     cfg_i,
  input  logic                clearing_i,
  input  logic                push_i,
  input  agacc_pkg::in_item_t item_i,
  output logic                full_o,
  output logic                cmd_push_o,
  output agacc_pkg::cmd_t     cmd_o,
  input  logic                cmd_full_i
);

  localparam int unsigned ROW_AW = $clog2(ROWS);
  localparam int unsigned ROW_W  = $bits(agacc_pkg::row_entry_t);

  logic                   accept, advance;
  logic                   row_ok, ann_ok, grp_ok, ivn_ok;
  logic                   row_we, row_re;
  logic [ROW_AW-1:0]      row_addr;
  agacc_pkg::row_entry_t  row_wdata, row_rdata;
  logic [ROW_W-1:0]       row_rdata_raw;
  agacc_pkg::cmd_t        s0_cmd;
  logic                   s0_lookup;
  logic                   s1_valid_q, s1_valid_d, s1_lookup_q;
  agacc_pkg::cmd_t        s1_cmd_q;
  logic                   s1_ann_ok, s1_grp_ok;

  assign advance = !s1_valid_q || !cmd_full_i;
  assign full_o  = clearing_i || !advance;
  assign accept  = push_i && !full_o;

  assign row_ok = 32'(item_i.row_index) < ROWS;
  assign ann_ok = (5'(item_i.row_annotation) < cfg_i.interventions_in_use)
               && (32'(item_i.row_annotation) < INTERVENTIONS);
  assign ivn_ok = (5'(item_i.intervention_index) < cfg_i.interventions_in_use)
               && (32'(item_i.intervention_index) < INTERVENTIONS);
  assign grp_ok = (7'(item_i.group_index) < cfg_i.groups_in_use)
               && (32'(item_i.group_index) < GROUPS);

  assign row_addr        = ROW_AW'(item_i.row_index);
  assign row_wdata.ann   = item_i.row_annotation;
  assign row_wdata.value = item_i.row_value;

  // Stage 0: classify and touch the row store
  always_comb begin
    s0_cmd        = '0;
    s0_cmd.op     = agacc_pkg::OP_NONE;
    s0_cmd.ann    = item_i.row_annotation;
    s0_cmd.grp    = item_i.group_index;
    s0_cmd.inc    = cfg_i.aggregate_mode ? agacc_pkg::VALUE_W'(1) : item_i.row_value;
    s0_lookup     = 1'b0;
    row_we        = 1'b0;
    row_re        = 1'b0;
    case (item_i.kind)
      agacc_pkg::KIND_LOAD: begin
        if (!row_ok || !ann_ok || (cfg_i.ungrouped_mode && cfg_i.groups_in_use == '0)) begin
          s0_cmd.status = 1'b1;
        end else begin
          row_we = accept;
          if (cfg_i.ungrouped_mode) begin
            s0_cmd.op  = agacc_pkg::OP_ADD;
            s0_cmd.grp = '0;
          end
        end
      end
      agacc_pkg::KIND_PAIR: begin
        if (!cfg_i.ungrouped_mode) begin
          if (!row_ok) begin
            s0_cmd.status = 1'b1;
          end else begin
            row_re    = accept;
            s0_lookup = 1'b1;
          end
        end
      end
      agacc_pkg::KIND_READ: begin
        if (ivn_ok && grp_ok) begin
          s0_cmd.op  = agacc_pkg::OP_READ;
          s0_cmd.ann = item_i.intervention_index;
        end else begin
          s0_cmd.status = 1'b1;
        end
      end
      default: begin
        s0_cmd.status = 1'b1;
      end
    endcase
  end

  agacc_ram #(
    .Width (ROW_W),
    .Depth (ROWS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_addr),
    .wdata_i (row_wdata),
    .re_i    (row_re),
    .raddr_i (row_addr),
    .rdata_o (row_rdata_raw)
  );

  assign row_rdata = agacc_pkg::row_entry_t'(row_rdata_raw);

  // Stage 1: pairs finish their check with the stored row
  assign s1_ann_ok = (5'(row_rdata.ann) < cfg_i.interventions_in_use)
                  && (32'(row_rdata.ann) < INTERVENTIONS);
  assign s1_grp_ok = (7'(s1_cmd_q.grp) < cfg_i.groups_in_use)
                  && (32'(s1_cmd_q.grp) < GROUPS);

  always_comb begin
    cmd_o = s1_cmd_q;
    if (s1_lookup_q) begin
      cmd_o.ann = row_rdata.ann;
      cmd_o.inc = cfg_i.aggregate_mode ? agacc_pkg::VALUE_W'(1) : row_rdata.value;
      if (s1_ann_ok && s1_grp_ok) begin
        cmd_o.op = agacc_pkg::OP_ADD;
      end else begin
        cmd_o.status = 1'b1;
      end
    end
  end

  assign cmd_push_o = s1_valid_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (advance) begin
      s1_valid_d = accept;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q    <= s0_cmd;
      s1_lookup_q <= s0_lookup;
    end
  end

  a_no_accept_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) clearing_i |-> !accept
  ) else $error("front accepted a beat during the clearing pass");

  a_s1_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && cmd_full_i |=> s1_valid_q && $stable(s1_cmd_q) && $stable(s1_lookup_q)
  ) else $error("stage 1 command changed while the command queue was full");

endmodule

// ----- hdl/agacc_back.sv -----
// Back end: clears accumulator after reset; reads it, or read-modify-writes for adds.
`timescale 1ns / 1ps
module agacc_back #(
  parameter int unsigned INTERVENTIONS = agacc_pkg::DEFAULT_INTERVENTIONS,
  parameter int unsigned GROUPS        = agacc_pkg::DEFAULT_GROUPS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  output logic                 clearing_o,
  input  agacc_pkg::cmd_t      cmd_i,
  input  logic                 cmd_empty_i,
  output logic                 cmd_pop_o,
  output logic                 res_push_o,
  output agacc_pkg::out_item_t res_o,
  input  logic                 res_full_i
);

  localparam int unsigned ENTRIES = INTERVENTIONS * GROUPS;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  agacc_pkg::bk_state_e     state_q, state_d;
  logic [IDX_W-1:0]         clr_q, clr_d;
  logic [IDX_W-1:0]         idx_q, head_idx;
  agacc_pkg::cmd_t          cur_q;
  logic                     acc_we, acc_re;
  logic [IDX_W-1:0]         acc_waddr;
  logic [agacc_pkg::VALUE_W-1:0] acc_wdata, acc_rdata, sum;

  assign head_idx = IDX_W'(cmd_i.ann) * IDX_W'(GROUPS) + IDX_W'(cmd_i.grp);
  assign sum      = acc_rdata + cur_q.inc;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      agacc_pkg::BK_CLEAR: begin
        if (clr_q == IDX_W'(ENTRIES - 1)) begin
          state_d = agacc_pkg::BK_IDLE;
        end
      end
      agacc_pkg::BK_IDLE: begin
        if (!cmd_empty_i) begin
          state_d = agacc_pkg::BK_EXEC;
        end
      end
      agacc_pkg::BK_EXEC: begin
        if (!res_full_i) begin
          state_d = agacc_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = agacc_pkg::BK_CLEAR;
      end
    endcase
  end

  // Outputs
  always_comb begin
    clearing_o        = 1'b0;
    acc_we            = 1'b0;
    acc_waddr         = idx_q;
    acc_wdata         = sum;
    acc_re            = 1'b0;
    cmd_pop_o         = 1'b0;
    res_push_o        = 1'b0;
    res_o             = '0;
    case (state_q)
      agacc_pkg::BK_CLEAR: begin
        clearing_o = 1'b1;
        acc_we     = 1'b1;
        acc_waddr  = clr_q;
        acc_wdata  = '0;
      end
      agacc_pkg::BK_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          acc_re    = (cmd_i.op != agacc_pkg::OP_NONE);
        end
      end
      agacc_pkg::BK_EXEC: begin
        if (!res_full_i) begin
          res_push_o   = 1'b1;
          res_o.status = cur_q.status;
          if (cur_q.op == agacc_pkg::OP_READ) begin
            res_o.entry_value = acc_rdata;
          end
          acc_we = (cur_q.op == agacc_pkg::OP_ADD);
        end
      end
      default: begin
        clearing_o = 1'b1;
      end
    endcase
  end

  assign clr_d = (state_q == agacc_pkg::BK_CLEAR) ? clr_q + 1'b1 : clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= agacc_pkg::BK_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cur_q <= cmd_i;
      idx_q <= head_idx;
    end
  end

  agacc_ram #(
    .Width (agacc_pkg::VALUE_W),
    .Depth (ENTRIES)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .re_i    (acc_re),
    .raddr_i (head_idx),
    .rdata_o (acc_rdata)
  );

  a_pop_to_exec: assert property (
    @(posedge clk_i) disable iff (!rst_ni) cmd_pop_o |=> state_q == agacc_pkg::BK_EXEC
  ) else $error("popped command not executed next cycle");

  a_clear_complete: assert property (
    @(posedge clk_i) disable iff (!rst_ni) $fell(clearing_o) |-> $past(clr_q) == IDX_W'(ENTRIES - 1)
  ) else $error("clearing pass ended early");

  a_add_only_write: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    acc_we && state_q == agacc_pkg::BK_EXEC |-> cur_q.op == agacc_pkg::OP_ADD && res_push_o
  ) else $error("accumulator written for a non-add command");

endmodule

// ----- hdl/annotated_group_accumulator_core.sv -----
// Path: front stage 1 register, command queue, back read then write, result queue.
// The back ends each command (accumulator read, then write on adds) before popping the next.
// Reset: config returns to sum mode, grouped, all groups and interventions in use.
// After reset the accumulator is zeroed one entry a cycle, all INTERVENTIONS*GROUPS entries
// (1024 by default), with full held high; config writes are taken throughout.
`timescale 1ns / 1ps
module annotated_group_accumulator_core #(
  parameter int unsigned ROWS          = agacc_pkg::DEFAULT_ROWS,
  parameter int unsigned INTERVENTIONS = agacc_pkg::DEFAULT_INTERVENTIONS,
  parameter int unsigned GROUPS        = agacc_pkg::DEFAULT_GROUPS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [agacc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [agacc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                                push,
  input  agacc_pkg::in_item_t                 in_item_i,
  output logic                                full,
  output logic                                empty,
  input  logic                                pop,
  output agacc_pkg::out_item_t                out_item_o
);

  agacc_pkg::cfg_t      cfg_q, cfg_d;
  logic                 clearing;
  logic                 cmd_push, cmd_full, cmd_empty, cmd_pop;
  agacc_pkg::cmd_t      cmd_in, cmd_head;
  logic                 res_push, res_full;
  agacc_pkg::out_item_t res;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        agacc_pkg::CFG_AGGREGATE_MODE:       cfg_d.aggregate_mode       = cfg_wdata_i[0];
        agacc_pkg::CFG_UNGROUPED_MODE:       cfg_d.ungrouped_mode       = cfg_wdata_i[0];
        agacc_pkg::CFG_GROUPS_IN_USE:        cfg_d.groups_in_use        = cfg_wdata_i[6:0];
        agacc_pkg::CFG_INTERVENTIONS_IN_USE: cfg_d.interventions_in_use = cfg_wdata_i[4:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.aggregate_mode       <= 1'b0;
      cfg_q.ungrouped_mode       <= 1'b0;
      cfg_q.groups_in_use        <= agacc_pkg::RESET_GROUPS_IN_USE;
      cfg_q.interventions_in_use <= agacc_pkg::RESET_INTERVENTIONS_IN_USE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  agacc_front #(
    .ROWS          (ROWS),
    .INTERVENTIONS (INTERVENTIONS),
    .GROUPS        (GROUPS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .clearing_i (clearing),
    .push_i     (push),
    .item_i     (in_item_i),
    .full_o     (full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full)
  );

  agacc_fifo #(
    .T     (agacc_pkg::cmd_t),
    .Depth (agacc_pkg::CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_head),
    .empty_o (cmd_empty)
  );

  agacc_back #(
    .INTERVENTIONS (INTERVENTIONS),
    .GROUPS        (GROUPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clearing_o  (clearing),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res),
    .res_full_i  (res_full)
  );

  agacc_fifo #(
    .T     (agacc_pkg::out_item_t),
    .Depth (agacc_pkg::RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_item_o),
    .empty_o (empty)
  );

endmodule

// ----- dv/annotated_group_accumulator_core_test.sv -----
// Self-checking testbench for the annotated group accumulator core.
`timescale 1ns / 1ps
module annotated_group_accumulator_core_test;
  import agacc_pkg::*;

  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_IGNORED = 1'b1;

  localparam int unsigned PHASES          = 12;
  localparam int unsigned ITEMS_PER_PHASE = 120;
  localparam int unsigned HOLD_CYCLES     = 80;
  localparam int unsigned TAIL_CYCLES     = 12;

  // one row of the directed table: either a register write or an item
  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [6:0]           reg_val;
    logic                 typed;
    logic [1:0]           kind;
    logic [9:0]           row;
    logic [3:0]           ann;
    logic [31:0]          val;
    logic [5:0]           grp;
    logic [3:0]           ivn;
    logic                 exp_status;
    logic [31:0]          exp_value;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic       push;
  in_item_t   in_item_i;
  logic       full;
  logic       empty;
  logic       pop;
  out_item_t  out_item_o;

  annotated_group_accumulator_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .in_item_i  (in_item_i),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  // shadow state of the block
  cfg_t        shadow_cfg;
  logic [3:0]  row_ann_mem [DEFAULT_ROWS];
  logic [31:0] row_val_mem [DEFAULT_ROWS];
  logic [31:0] acc_mem [DEFAULT_INTERVENTIONS][DEFAULT_GROUPS] = '{default: '0};
  bit          row_loaded [DEFAULT_ROWS];
  int unsigned loaded_rows [$];

  out_item_t   outcome_q [$];
  out_item_t   want;
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned directed_items;
  int unsigned random_items;
  int unsigned burst_left;
  bit          hold_req;

  cfg_t preset_cfg [8] = '{
    '{1'b0, 1'b0, 7'd64,  5'd16},
    '{1'b1, 1'b0, 7'd64,  5'd16},
    '{1'b0, 1'b1, 7'd64,  5'd16},
    '{1'b1, 1'b1, 7'd1,   5'd1},
    '{1'b0, 1'b0, 7'd1,   5'd1},
    '{1'b0, 1'b0, 7'd127, 5'd31},
    '{1'b1, 1'b0, 7'd0,   5'd0},
    '{1'b0, 1'b1, 7'd0,   5'd16}
  };

  dir_row_t directed_rows [$] = '{
    // reset state reads back zero
    '{1'b0, CFG_AGGREGATE_MODE, 7'd0, 1'b1, KIND_READ, 10'd0, 4'd0, 32'd0,
      6'd0, 4'd0, ST_DONE, 32'd0},
    '{1'b0, CFG_AGGREGATE_MODE, 7'd0, 1'b1, KIND_READ, 10'd0, 4'd0, 32'd0,
      6'd63, 4'd15, ST_DONE, 32'd0},
    '{1'b0, CFG_AGGREGATE_MODE, 7'd0, 1'b1, KIND_UNKNOWN, 10'd1023, 4'd15,
      32'hFFFF_FFFF, 6'd63, 4'd15, ST_IGNORED, 32'd0},
    '{1'b0, CFG_AGGREGATE_MODE, 7'd0, 1'b1, KIND_LOAD, 10'd0, 4'd0,
      32'h7FFF_FFFF, 6'd0, 4'd0, ST_DONE, 32'd0},
    '{1'b0, CFG_AGGREGATE_MODE, 7'd0, 1'b1, KIND_LOAD, 10'd1023, 4'd15,
      32'h8000_0000, 6'd0, 4'd0, ST_DONE, 32'd0},
    '{1'b0, CFG_AGGREGATE_MODE, 7'd0, 1'b1, KIND_LOAD, 10'd1, 4'd0, 32'd1,
      6'd0, 4'd0, ST_DONE, 32'd0},
    // sum wraps past the top of the range
    '{1'b0, CFG_AGGREGATE_MODE, 7'd0, 1'b0, KIND_PAIR, 10'd0, 4'd0, 32'd0,
      6'd0, 4'd0, ST_DONE, 32'd0},
    '{1'b0, CFG_AGGREGATE_MODE, 7'd0, 1'b0, KIND_PAIR, 10'd1, 4'd0, 32'd0,
      6'd0, 4'd0, ST_DONE, 32'd0},
    '{1'b0, CFG_AGGREGATE_MODE, 7'd0, 1'b0, KIND_PAIR, 10'd1023, 4'd0, 32'd0,
      6'd63, 4'd0, ST_DONE, 32'd0},
    '{1'b0, CFG_AGGREGATE_MODE, 7'd0, 1'b0, KIND_READ, 10'd0, 4'd0, 32'd0,
      6'd0, 4'd0, ST_DONE, 32'd0},
    '{1'b0, CFG_AGGREGATE_MODE, 7'd0, 1'b0, KIND_READ, 10'd0, 4'd0, 32'd0,
      6'd63, 4'd15, ST_DONE, 32'd0},
    // narrow limits: out-of-range load, pair and read
    '{1'b1, CFG_INTERVENTIONS_IN_USE, 7'd4, 1'b0, KIND_LOAD, 10'd0, 4'd0, 32'd0,
      6'd0, 4'd0, ST_DONE, 32'd0},
    '{1'b1, CFG_GROUPS_IN_USE, 7'd8, 1'b0, KIND_LOAD, 10'd0, 4'd0, 32'd0,
      6'd0, 4'd0, ST_DONE, 32'd0},
    '{1'b0, CFG_AGGREGATE_MODE, 7'd0, 1'b1, KIND_LOAD, 10'd2, 4'd4, 32'd9,
      6'd0, 4'd0, ST_IGNORED, 32'd0},
    '{1'b0, CFG_AGGREGATE_MODE, 7'd0, 1'b1, KIND_PAIR, 10'd1023, 4'd0, 32'd0,
      6'd0, 4'd0, ST_IGNORED, 32'd0},
    '{1'b0, CFG_AGGREGATE_MODE, 7'd0, 1'b1, KIND_PAIR, 10'd0, 4'd0, 32'd0,
      6'd8, 4'd0, ST_IGNORED, 32'd0},
    '{1'b0, CFG_AGGREGATE_MODE, 7'd0, 1'b1, KIND_READ, 10'd0, 4'd0, 32'd0,
      6'd0, 4'd4, ST_IGNORED, 32'd0},
    '{1'b0, CFG_AGGREGATE_MODE, 7'd0, 1'b1, KIND_READ, 10'd0, 4'd0, 32'd0,
      6'd8, 4'd0, ST_IGNORED, 32'd0},
    // count mode, ungrouped: pair ignored without error, load counts
    '{1'b1, CFG_AGGREGATE_MODE, 7'd1, 1'b0, KIND_LOAD, 10'd0, 4'd0, 32'd0,
      6'd0, 4'd0, ST_DONE, 32'd0},
    '{1'b1, CFG_UNGROUPED_MODE, 7'd1, 1'b0, KIND_LOAD, 10'd0, 4'd0, 32'd0,
      6'd0, 4'd0, ST_DONE, 32'd0},
    '{1'b0, CFG_AGGREGATE_MODE, 7'd0, 1'b1, KIND_PAIR, 10'd0, 4'd0, 32'd0,
      6'd5, 4'd0, ST_DONE, 32'd0},
    '{1'b0, CFG_AGGREGATE_MODE, 7'd0, 1'b1, KIND_LOAD, 10'd3, 4'd3,
      32'hFFFF_FFFB, 6'd0, 4'd0, ST_DONE, 32'd0},
    '{1'b0, CFG_AGGREGATE_MODE, 7'd0, 1'b0, KIND_READ, 10'd0, 4'd0, 32'd0,
      6'd0, 4'd3, ST_DONE, 32'd0},
    // zero groups: ungrouped load has nowhere to go
    '{1'b1, CFG_GROUPS_IN_USE, 7'd0, 1'b0, KIND_LOAD, 10'd0, 4'd0, 32'd0,
      6'd0, 4'd0, ST_DONE, 32'd0},
    '{1'b0, CFG_AGGREGATE_MODE, 7'd0, 1'b1, KIND_LOAD, 10'd4, 4'd1, 32'd7,
      6'd0, 4'd0, ST_IGNORED, 32'd0},
    '{1'b0, CFG_AGGREGATE_MODE, 7'd0, 1'b1, KIND_READ, 10'd0, 4'd0, 32'd0,
      6'd0, 4'd0, ST_IGNORED, 32'd0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("Timeout: %0d results still outstanding", outcome_q.size());
    $display("TEST FAILED");
    $finish;
  end

  function automatic int unsigned interventions_limit();
    return (shadow_cfg.interventions_in_use < DEFAULT_INTERVENTIONS) ?
           shadow_cfg.interventions_in_use : DEFAULT_INTERVENTIONS;
  endfunction

  function automatic int unsigned groups_limit();
    return (shadow_cfg.groups_in_use < DEFAULT_GROUPS) ?
           shadow_cfg.groups_in_use : DEFAULT_GROUPS;
  endfunction

  // Predicts the outcome of one beat and updates the shadow stores.
  function automatic out_item_t aggregate_step(in_item_t it);
    out_item_t   res;
    int unsigned lim_i;
    int unsigned lim_g;
    logic [3:0]  ann;
    logic [31:0] addend;
    res   = '0;
    lim_i = interventions_limit();
    lim_g = groups_limit();
    case (it.kind)
      KIND_LOAD: begin
        if (it.row_annotation >= lim_i || (shadow_cfg.ungrouped_mode && lim_g == 0)) begin
          res.status = ST_IGNORED;
        end else begin
          row_ann_mem[it.row_index] = it.row_annotation;
          row_val_mem[it.row_index] = it.row_value;
          if (!row_loaded[it.row_index]) begin
            row_loaded[it.row_index] = 1'b1;
            loaded_rows.insert(loaded_rows.size(), 32'(it.row_index));
          end
          if (shadow_cfg.ungrouped_mode) begin
            addend = shadow_cfg.aggregate_mode ? 32'd1 : it.row_value;
            acc_mem[it.row_annotation][0] = acc_mem[it.row_annotation][0] + addend;
          end
        end
      end
      KIND_PAIR: begin
        if (!shadow_cfg.ungrouped_mode) begin
          ann = row_ann_mem[it.row_index];
          if (ann >= lim_i || it.group_index >= lim_g) begin
            res.status = ST_IGNORED;
          end else begin
            addend = shadow_cfg.aggregate_mode ? 32'd1 : row_val_mem[it.row_index];
            acc_mem[ann][it.group_index] = acc_mem[ann][it.group_index] + addend;
          end
        end
      end
      KIND_READ: begin
        if (it.intervention_index >= lim_i || it.group_index >= lim_g)
          res.status = ST_IGNORED;
        else
          res.entry_value = acc_mem[it.intervention_index][it.group_index];
      end
      default: res.status = ST_IGNORED;
    endcase
    return res;
  endfunction

  // Random beat; pairs only name rows already loaded.
  function automatic in_item_t draw_item();
    in_item_t    it;
    int unsigned pick;
    int unsigned lim_i;
    int unsigned lim_g;
    pick  = $urandom_range(0, 99);
    lim_i = interventions_limit();
    lim_g = groups_limit();
    it.kind               = KIND_READ;
    it.row_index          = 10'($urandom);
    it.row_annotation     = 4'($urandom);
    it.group_index        = 6'($urandom);
    it.intervention_index = 4'($urandom);
    case ($urandom_range(0, 7))
      0: it.row_value = 32'h7FFF_FFFF;
      1: it.row_value = 32'h8000_0000;
      2: it.row_value = 32'hFFFF_FFFF;
      3: it.row_value = $urandom_range(0, 3);
      default: it.row_value = $urandom;
    endcase
    if (pick < 5) begin
      it.kind = KIND_UNKNOWN;
    end else if (pick < 35 || loaded_rows.size() == 0) begin
      it.kind = KIND_LOAD;
      if ($urandom_range(0, 1) == 0)
        it.row_index = 10'($urandom_range(0, 31));
      if (lim_i > 0 && $urandom_range(0, 9) != 0)
        it.row_annotation = 4'($urandom_range(0, lim_i - 1));
    end else if (pick < 75) begin
      it.kind      = KIND_PAIR;
      it.row_index = 10'(loaded_rows[$urandom_range(0, loaded_rows.size() - 1)]);
      if (lim_g > 0 && $urandom_range(0, 6) != 0)
        it.group_index = 6'($urandom_range(0, lim_g - 1));
    end else begin
      if (lim_i > 0 && $urandom_range(0, 9) != 0)
        it.intervention_index = 4'($urandom_range(0, lim_i - 1));
      if (lim_g > 0 && $urandom_range(0, 9) != 0)
        it.group_index = 6'($urandom_range(0, lim_g - 1));
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    mismatches++;
    if (mismatches <= 100)
      $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, exp_val);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [6:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    case (idx)
      CFG_AGGREGATE_MODE:       shadow_cfg.aggregate_mode       = data[0];
      CFG_UNGROUPED_MODE:       shadow_cfg.ungrouped_mode       = data[0];
      CFG_GROUPS_IN_USE:        shadow_cfg.groups_in_use        = data[6:0];
      CFG_INTERVENTIONS_IN_USE: shadow_cfg.interventions_in_use = data[4:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic wait_drain();
    while (outcome_q.size() != 0) @(posedge clk_i);
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_item(in_item_t it, logic typed, out_item_t typed_res);
    out_item_t predicted;
    push      = 1'b1;
    in_item_i = it;
    do @(posedge clk_i); while (full);
    predicted = aggregate_step(it);
    outcome_q.insert(outcome_q.size(), typed ? typed_res : predicted);
    @(negedge clk_i);
  endtask

  // Bursts of back-to-back beats separated by random gaps.
  task automatic sender_pace();
    if (hold_req) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      push = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) :
                                                $urandom_range(0, 12);
    end
  endtask

  // Receiver: pop pattern changes per window; a long hold-off on request.
  initial begin
    int unsigned window_left;
    int unsigned rx_mode;
    int unsigned rx_tick;
    window_left = 0;
    rx_mode     = 0;
    rx_tick     = 0;
    pop         = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pop = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (window_left == 0) begin
        rx_mode     = $urandom_range(0, 3);
        window_left = $urandom_range(16, 96);
      end
      window_left--;
      rx_tick++;
      case (rx_mode)
        0: pop = 1'b1;
        1: pop = ($urandom_range(0, 9) < 7);
        2: pop = (rx_tick % 4 == 0);
        default: pop = ($urandom_range(0, 9) < 2);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("unexpected result", out_item_o.entry_value, 32'd0);
      end else begin
        want = outcome_q.pop_front();
        results_checked++;
        if (out_item_o.status !== want.status)
          report_mismatch("status", 32'(out_item_o.status), 32'(want.status));
        if (out_item_o.entry_value !== want.entry_value)
          report_mismatch("entry_value", out_item_o.entry_value, want.entry_value);
      end
    end
  end

  initial begin
    in_item_t  it;
    out_item_t typed_res;
    cfg_t      next_cfg;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_AGGREGATE_MODE;
    cfg_wdata_i     = '0;
    push            = 1'b0;
    in_item_i       = '0;
    hold_req        = 1'b0;
    burst_left      = 0;
    mismatches      = 0;
    results_checked = 0;
    directed_items  = 0;
    random_items    = 0;
    shadow_cfg      = '{1'b0, 1'b0, RESET_GROUPS_IN_USE, RESET_INTERVENTIONS_IN_USE};
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        push = 1'b0;
        wait_drain();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        it.kind               = directed_rows[i].kind;
        it.row_index          = directed_rows[i].row;
        it.row_annotation     = directed_rows[i].ann;
        it.row_value          = directed_rows[i].val;
        it.group_index        = directed_rows[i].grp;
        it.intervention_index = directed_rows[i].ivn;
        typed_res.status      = directed_rows[i].exp_status;
        typed_res.entry_value = directed_rows[i].exp_value;
        send_item(it, directed_rows[i].typed, typed_res);
        directed_items++;
        sender_pace();
      end
    end

    for (int unsigned p = 0; p < PHASES; p++) begin
      push = 1'b0;
      wait_drain();
      if (p < 8) begin
        next_cfg = preset_cfg[p];
      end else begin
        next_cfg.aggregate_mode       = 1'($urandom_range(0, 1));
        next_cfg.ungrouped_mode       = 1'($urandom_range(0, 1));
        next_cfg.groups_in_use        = 7'($urandom_range(1, 64));
        next_cfg.interventions_in_use = 5'($urandom_range(1, 16));
      end
      write_reg(CFG_AGGREGATE_MODE, 7'(next_cfg.aggregate_mode));
      write_reg(CFG_UNGROUPED_MODE, 7'(next_cfg.ungrouped_mode));
      write_reg(CFG_GROUPS_IN_USE, next_cfg.groups_in_use);
      write_reg(CFG_INTERVENTIONS_IN_USE, 7'(next_cfg.interventions_in_use));
      // keep offering beats while the receiver is held off so both queues fill
      if (p == 1) hold_req = 1'b1;
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_item(draw_item(), 1'b0, '0);
        random_items++;
        sender_pace();
      end
    end

    push = 1'b0;
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d directed and %0d random beats over %0d register settings,",
             directed_items, random_items, PHASES + 4);
    $display("%0d results checked, %0d rows loaded, %0d mismatches.",
             results_checked, loaded_rows.size(), mismatches);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
